>>> rtl/whp_pkg.sv
// Package: phases, status codes, sample kinds and interface payload types for the WAV parser
`timescale 1ns / 1ps
package whp_pkg;

  typedef enum logic [3:0] {
    PH_IDLE, PH_RIFF, PH_RSIZE, PH_WAVE, PH_FMT_ID, PH_FMT_OSIZE, PH_FMT_SKIP,
    PH_FMT_SIZE, PH_FMT_BODY, PH_FMT_TAIL, PH_DATA_ID, PH_DATA_OSIZE,
    PH_DATA_SKIP, PH_DATA_SIZE, PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    CS_IDLE, CS_PARSE, CS_DIV_FRAMES, CS_MUL_MS, CS_DIV_MS, CS_OUT
  } ctrl_state_t;

  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_NO_RIFF  = 4'd1;
  localparam logic [3:0] ST_NO_WAVE  = 4'd2;
  localparam logic [3:0] ST_TRUNC    = 4'd3;
  localparam logic [3:0] ST_BAD_TAG  = 4'd4;
  localparam logic [3:0] ST_BAD_EXT  = 4'd5;
  localparam logic [3:0] ST_BAD_TYPE = 4'd6;
  localparam logic [3:0] ST_BAD_ALGN = 4'd7;
  localparam logic [3:0] ST_TOO_LONG = 4'd8;
  localparam logic [3:0] ST_ZERO     = 4'd9;

  localparam logic [31:0] MARK_RIFF = 32'h4646_4952;
  localparam logic [31:0] MARK_WAVE = 32'h4556_4157;
  localparam logic [31:0] MARK_FMT  = 32'h2074_6D66;
  localparam logic [31:0] MARK_DATA = 32'h6174_6164;

  localparam logic [15:0] TAG_PCM   = 16'h0001;
  localparam logic [15:0] TAG_FLOAT = 16'h0003;
  localparam logic [15:0] TAG_EXT   = 16'hFFFE;

  localparam logic [2:0] SK_INT8  = 3'd0;
  localparam logic [2:0] SK_INT16 = 3'd1;
  localparam logic [2:0] SK_INT24 = 3'd2;
  localparam logic [2:0] SK_INT32 = 3'd3;
  localparam logic [2:0] SK_FLT32 = 3'd4;

  localparam logic [15:0] EXT_LEN = 16'd22;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] channels;
    logic [31:0] sample_rate;
    logic [2:0]  sample_format;
    logic [31:0] speaker_mask;
    logic [31:0] total_frames;
    logic [41:0] total_time_ms;
    logic [31:0] data_offset;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic step;       // consume one byte
    logic div_start;  // load divider
    logic div_ms;     // 0: frames, 1: ms
    logic div_step;
    logic mul_ms;     // frames * 1000
    logic emit;       // load output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic byte_done;  // parse finished on this byte
    logic need_div;   // finished ok, divisions follow
    logic div_last;
  } dp_stat_t;

  // GUID bytes after the first, for the extensible sub-format
  function automatic logic [7:0] guid_tail(input logic [3:0] idx);
    logic [7:0] r;
    case (idx)
      4'd5:  r = 8'h10;
      4'd7:  r = 8'h80;
      4'd10: r = 8'hAA;
      4'd12: r = 8'h38;
      4'd13: r = 8'h9B;
      4'd14: r = 8'h71;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/whp_if.sv
// Valid/ready stream interfaces for the WAV parser
`timescale 1ns / 1ps
interface whp_in_if;
  logic                valid;
  logic                ready;
  whp_pkg::in_item_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface whp_out_if;
  logic                valid;
  logic                ready;
  whp_pkg::out_item_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface whp_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/whp_ctrl.sv
// Controller: sequences byte intake, the two divisions of the shared divider and the result register
`timescale 1ns / 1ps
module whp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_valid,
  input  logic              out_ready,
  input  whp_pkg::dp_stat_t stat,
  output whp_pkg::dp_cmd_t  cmd
);

  whp_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= whp_pkg::CS_PARSE;
    else     state <= state_next;
  end

  // output register is free or draining this cycle
  logic out_free;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      whp_pkg::CS_PARSE: begin
        in_ready = out_free;
        if (in_valid && in_ready) begin
          cmd.step = 1'b1;
          if (stat.need_div) begin
            cmd.div_start = 1'b1;
            state_next = whp_pkg::CS_DIV_FRAMES;
          end else if (stat.byte_done) begin
            cmd.emit = 1'b1;
          end
        end
      end
      whp_pkg::CS_DIV_FRAMES: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = whp_pkg::CS_MUL_MS;
      end
      whp_pkg::CS_MUL_MS: begin
        cmd.mul_ms = 1'b1;
        cmd.div_start = 1'b1;
        cmd.div_ms = 1'b1;
        state_next = whp_pkg::CS_DIV_MS;
      end
      whp_pkg::CS_DIV_MS: begin
        cmd.div_step = 1'b1;
        cmd.div_ms = 1'b1;
        if (stat.div_last) state_next = whp_pkg::CS_OUT;
      end
      whp_pkg::CS_OUT: begin
        if (out_free) begin
          cmd.emit = 1'b1;
          state_next = whp_pkg::CS_PARSE;
        end
      end
      default: state_next = whp_pkg::CS_PARSE;
    endcase
  end

`ifndef SYNTHESIS
  a_no_intake_while_div: assert property (@(posedge clk) disable iff (rst)
    (state == whp_pkg::CS_DIV_FRAMES || state == whp_pkg::CS_DIV_MS) |-> !in_ready)
    else $error("byte taken during division");
  a_div_to_mul: assert property (@(posedge clk) disable iff (rst)
    (state == whp_pkg::CS_DIV_FRAMES && stat.div_last) |=> state == whp_pkg::CS_MUL_MS)
    else $error("frame division not followed by ms step");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> out_free)
    else $error("result loaded over pending result");
`endif

endmodule

>>> rtl/whp_dp.sv
// Datapath: byte parser registers, shared restoring divider and result register
`timescale 1ns / 1ps
module whp_dp (
  input  logic              clk,
  input  logic              rst,
  input  whp_pkg::dp_cmd_t  cmd,
  output whp_pkg::dp_stat_t stat,
  input  logic [7:0]        data_byte,
  input  logic              first_byte,
  input  logic [31:0]       file_length,
  output whp_pkg::out_item_t result
);

  whp_pkg::phase_t phase;
  logic [31:0] byte_offset;   // never exceeds file_length
  logic [5:0]  field_count;
  logic [31:0] skip_remaining;
  logic [31:0] assemble_word;
  logic [32:0] fmt_chunk_end;
  logic [15:0] fmt_tag, fmt_ch, fmt_align, fmt_bits;
  logic [31:0] rate_reg, mask_reg;
  logic [1:0]  guid_match;
  logic [2:0]  sample_kind;
  logic [31:0] data_start;
  logic [18:0] frame_bytes;

  // per-byte next values
  whp_pkg::phase_t phase_next;
  logic [31:0] off_next, skip_next, w;
  logic [5:0]  fc_next, i;
  logic [32:0] fce_next;
  logic [15:0] tag_next, ch_next, align_next, bits_next;
  logic [31:0] rate_next, mask_next;
  logic [1:0]  gm_next;
  logic [2:0]  sk_next;
  logic        fin, fin_ok;
  logic [3:0]  fin_st;

  logic [32:0] off_ext, len_ext;
  assign len_ext = {1'b0, file_length};

  // bytes per frame; format fields are stable once the data chunk is reached
  assign frame_bytes = 19'(fmt_ch) * 19'(fmt_bits[5:3]);

  // end of fmt chunk checks; returns status and sets sample kind
  function automatic logic [3:0] chk_fmt(input logic is_f, input logic [15:0] bits,
                                         input logic [15:0] ch, input logic [15:0] al,
                                         output logic [2:0] sk);
    logic [3:0] st;
    st = whp_pkg::ST_OK;
    sk = whp_pkg::SK_INT8;
    if (is_f && bits == 16'd32)       sk = whp_pkg::SK_FLT32;
    else if (!is_f && bits == 16'd32) sk = whp_pkg::SK_INT32;
    else if (!is_f && bits == 16'd24) sk = whp_pkg::SK_INT24;
    else if (!is_f && bits == 16'd16) sk = whp_pkg::SK_INT16;
    else if (!is_f && bits == 16'd8)  sk = whp_pkg::SK_INT8;
    else st = whp_pkg::ST_BAD_TYPE;
    if (st == whp_pkg::ST_OK) begin
      // bits/8 is 1..4, so the product fits 32 bits
      if ({16'd0, al} != 32'(ch) * 32'(bits[15:3])) st = whp_pkg::ST_BAD_ALGN;
    end
    return st;
  endfunction

  always_comb begin
    logic [3:0]  st;
    logic [2:0]  skk;
    logic [32:0] sz_end;
    logic [32:0] tail;
    logic        is_f;
    logic [7:0]  ep, ef;
    logic [3:0]  g;
    logic [32:0] remain;
    phase_next = phase; off_next = byte_offset; fc_next = field_count;
    skip_next = skip_remaining; fce_next = fmt_chunk_end;
    tag_next = fmt_tag; ch_next = fmt_ch; align_next = fmt_align; bits_next = fmt_bits;
    rate_next = rate_reg; mask_next = mask_reg; gm_next = guid_match; sk_next = sample_kind;
    fin = 1'b0; fin_ok = 1'b0; fin_st = whp_pkg::ST_OK;
    st = whp_pkg::ST_OK; skk = '0; sz_end = '0; tail = '0; is_f = 1'b0;
    ep = '0; ef = '0; g = '0; remain = '0; w = '0; i = '0; off_ext = '0;
    if (first_byte) begin
      phase_next = whp_pkg::PH_RIFF; off_next = '0; fc_next = '0; skip_next = '0;
      fce_next = '0; tag_next = '0; ch_next = '0; align_next = '0; bits_next = '0;
      rate_next = '0; mask_next = '0; gm_next = 2'b11; sk_next = '0;
    end
    if (phase_next != whp_pkg::PH_IDLE && phase_next != whp_pkg::PH_DONE) begin
      if (off_next >= file_length) begin
        fin = 1'b1; fin_st = whp_pkg::ST_TRUNC;
      end else begin
        w = {data_byte, (first_byte ? 24'd0 : assemble_word[31:8])};
        i = fc_next;
        off_next = off_next + 32'd1;
        off_ext = {1'b0, off_next};
        fc_next = fc_next + 6'd1;
        case (phase_next)
          whp_pkg::PH_RIFF: if (fc_next == 6'd4) begin
            if (w != whp_pkg::MARK_RIFF) begin fin = 1'b1; fin_st = whp_pkg::ST_NO_RIFF; end
            else begin phase_next = whp_pkg::PH_RSIZE; fc_next = '0; end
          end
          whp_pkg::PH_RSIZE: if (fc_next == 6'd4) begin
            phase_next = whp_pkg::PH_WAVE; fc_next = '0;
          end
          whp_pkg::PH_WAVE: if (fc_next == 6'd4) begin
            if (w != whp_pkg::MARK_WAVE) begin fin = 1'b1; fin_st = whp_pkg::ST_NO_WAVE; end
            else begin phase_next = whp_pkg::PH_FMT_ID; fc_next = '0; end
          end
          whp_pkg::PH_FMT_ID: if (fc_next == 6'd4) begin
            fc_next = '0;
            phase_next = (w == whp_pkg::MARK_FMT) ? whp_pkg::PH_FMT_SIZE
                                                  : whp_pkg::PH_FMT_OSIZE;
          end
          whp_pkg::PH_DATA_ID: if (fc_next == 6'd4) begin
            fc_next = '0;
            phase_next = (w == whp_pkg::MARK_DATA) ? whp_pkg::PH_DATA_SIZE
                                                   : whp_pkg::PH_DATA_OSIZE;
          end
          whp_pkg::PH_FMT_OSIZE, whp_pkg::PH_DATA_OSIZE: if (fc_next == 6'd4) begin
            sz_end = off_ext + {1'b0, w};
            if (sz_end > len_ext) begin fin = 1'b1; fin_st = whp_pkg::ST_TRUNC; end
            else begin
              fc_next = '0;
              if (w == '0)
                phase_next = (phase == whp_pkg::PH_FMT_OSIZE) ? whp_pkg::PH_FMT_ID
                                                              : whp_pkg::PH_DATA_ID;
              else begin
                skip_next = w;
                phase_next = (phase == whp_pkg::PH_FMT_OSIZE) ? whp_pkg::PH_FMT_SKIP
                                                              : whp_pkg::PH_DATA_SKIP;
              end
            end
          end
          whp_pkg::PH_FMT_SKIP, whp_pkg::PH_DATA_SKIP, whp_pkg::PH_FMT_TAIL: begin
            fc_next = '0;
            skip_next = skip_next - 32'd1;
            if (skip_next == '0)
              phase_next = (phase == whp_pkg::PH_FMT_SKIP) ? whp_pkg::PH_FMT_ID
                                                           : whp_pkg::PH_DATA_ID;
          end
          whp_pkg::PH_FMT_SIZE: if (fc_next == 6'd4) begin
            fce_next = off_ext + {1'b0, w};
            if (w < 32'd16) begin fin = 1'b1; fin_st = whp_pkg::ST_TRUNC; end
            else begin phase_next = whp_pkg::PH_FMT_BODY; fc_next = '0; end
          end
          whp_pkg::PH_FMT_BODY: begin
            if (i == 6'd1) begin
              tag_next = w[31:16];
              if (tag_next != whp_pkg::TAG_PCM && tag_next != whp_pkg::TAG_FLOAT &&
                  tag_next != whp_pkg::TAG_EXT) begin
                fin = 1'b1; fin_st = whp_pkg::ST_BAD_TAG;
              end
            end else if (i == 6'd3) ch_next = w[31:16];
            else if (i == 6'd7) rate_next = w;
            else if (i == 6'd13) align_next = w[31:16];
            else if (i == 6'd15) begin
              bits_next = w[31:16];
              if (tag_next != whp_pkg::TAG_EXT) begin
                is_f = (tag_next == whp_pkg::TAG_FLOAT);
                if (bits_next[2:0] != 3'd0) st = whp_pkg::ST_BAD_TYPE;
                else st = chk_fmt(is_f, bits_next, ch_next, align_next, skk);
              end
            end else if (i == 6'd17) begin
              if (w[31:16] != whp_pkg::EXT_LEN) begin fin = 1'b1; fin_st = whp_pkg::ST_BAD_EXT; end
              else if (bits_next[2:0] != 3'd0) begin
                fin = 1'b1; fin_st = whp_pkg::ST_BAD_TYPE;
              end else if (fce_next < off_ext + 33'd22) begin
                fin = 1'b1; fin_st = whp_pkg::ST_TRUNC;
              end
            end else if (i == 6'd23) mask_next = w;
            else if (i >= 6'd24 && i <= 6'd39) begin
              g = 4'(i - 6'd24);
              ep = (g == 4'd0) ? 8'h01 : whp_pkg::guid_tail(g - 4'd1);
              ef = (g == 4'd0) ? 8'h03 : whp_pkg::guid_tail(g - 4'd1);
              if (data_byte != ep) gm_next[0] = 1'b0;
              if (data_byte != ef) gm_next[1] = 1'b0;
              if (i == 6'd39) begin
                if (gm_next[0]) begin is_f = 1'b0; st = chk_fmt(1'b0, bits_next, ch_next,
                                                                align_next, skk); end
                else if (gm_next[1]) begin is_f = 1'b1; st = chk_fmt(1'b1, bits_next, ch_next,
                                                                    align_next, skk); end
                else st = whp_pkg::ST_BAD_EXT;
              end
            end
            // fmt end reached: fail on st or truncation, else pass on with any tail skip
            if ((i == 6'd15 && tag_next != whp_pkg::TAG_EXT) || i == 6'd39) begin
              if (st != whp_pkg::ST_OK) begin fin = 1'b1; fin_st = st; end
              else if (fce_next > len_ext) begin fin = 1'b1; fin_st = whp_pkg::ST_TRUNC; end
              else begin
                sk_next = skk;
                tail = fce_next - off_ext;
                fc_next = '0;
                if (tail == '0) phase_next = whp_pkg::PH_DATA_ID;
                else begin skip_next = tail[31:0]; phase_next = whp_pkg::PH_FMT_TAIL; end
              end
            end
          end
          whp_pkg::PH_DATA_SIZE: if (fc_next == 6'd4) begin
            remain = len_ext - off_ext;
            fin = 1'b1;
            if ({1'b0, w} > remain) fin_st = whp_pkg::ST_TOO_LONG;
            else if (ch_next == '0 || rate_next == '0) fin_st = whp_pkg::ST_ZERO;
            else fin_ok = 1'b1;
          end
          default: ;
        endcase
        if (!fin && off_next >= file_length) begin fin = 1'b1; fin_st = whp_pkg::ST_TRUNC; end
      end
    end
  end

  assign stat.byte_done = fin;
  assign stat.need_div  = fin && fin_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= whp_pkg::PH_IDLE;
    end else if (cmd.step) begin
      phase <= fin ? whp_pkg::PH_DONE : phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset <= '0; field_count <= '0; skip_remaining <= '0; assemble_word <= '0;
      fmt_chunk_end <= '0; fmt_tag <= '0; fmt_ch <= '0; fmt_align <= '0; fmt_bits <= '0;
      rate_reg <= '0; mask_reg <= '0; guid_match <= 2'b11; sample_kind <= '0;
    end else if (cmd.step) begin
      byte_offset <= off_next; field_count <= fc_next; skip_remaining <= skip_next;
      assemble_word <= w; fmt_chunk_end <= fce_next;
      fmt_tag <= tag_next; fmt_ch <= ch_next; fmt_align <= align_next; fmt_bits <= bits_next;
      rate_reg <= rate_next; mask_reg <= mask_next; guid_match <= gm_next; sample_kind <= sk_next;
    end
  end

  // data offset kept for the result
  always_ff @(posedge clk) begin
    if (cmd.step && fin_ok) begin
      data_start  <= off_next;
    end
  end

  // shared restoring divider, one quotient bit per cycle, 42-bit dividend
  logic [41:0] dvd;
  logic [31:0] dvs;
  logic [32:0] rem;
  logic [5:0]  cnt;
  logic [31:0] frames;
  logic [41:0] ms_prod;
  logic [33:0] trial;
  logic [32:0] rem_sh;

  assign rem_sh = {rem[31:0], dvd[41]};
  assign trial  = {1'b0, rem_sh} - {2'b0, dvs};
  assign stat.div_last = (cmd.div_ms ? cnt == 6'd41 : cnt == 6'd31);

  always_ff @(posedge clk) begin
    if (cmd.div_start && !cmd.div_ms) begin
      // loaded on the data size byte itself
      dvd <= {w, 10'd0};
      dvs <= {13'd0, frame_bytes};
      rem <= '0; cnt <= '0;
    end else if (cmd.div_start) begin
      dvd <= ms_prod;
      dvs <= rate_reg;
      rem <= '0; cnt <= '0;
    end else if (cmd.div_step) begin
      if (!trial[33]) begin
        rem <= trial[32:0];
        dvd <= {dvd[40:0], 1'b1};
      end else begin
        rem <= rem_sh;
        dvd <= {dvd[40:0], 1'b0};
      end
      cnt <= cnt + 6'd1;
    end
  end

  // frames*1000 as shifts and adds: x*1024 - x*16 - x*8
  always_comb begin
    ms_prod = {frames, 10'd0} - {6'd0, frames, 4'd0} - {7'd0, frames, 3'd0};
  end

  // 31 quotient bits sit at the bottom of dvd before the last step
  always_ff @(posedge clk) begin
    if (cmd.div_step && !cmd.div_ms && stat.div_last) frames <= {dvd[30:0], !trial[33]};
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (cmd.step) begin
        result <= '{status: fin_st, default: '0};
      end else begin
        result.status        <= whp_pkg::ST_OK;
        result.channels      <= fmt_ch;
        result.sample_rate   <= rate_reg;
        result.sample_format <= sample_kind;
        result.speaker_mask  <= mask_reg;
        result.total_frames  <= frames;
        result.total_time_ms <= dvd;
        result.data_offset   <= data_start;
      end
    end
  end

`ifndef SYNTHESIS
  a_done_stays: assert property (@(posedge clk) disable iff (rst)
    (phase == whp_pkg::PH_DONE && !(cmd.step && first_byte)) |=> phase == whp_pkg::PH_DONE)
    else $error("left done without first byte");
  a_offset_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && !fin &&
     (first_byte || (phase != whp_pkg::PH_IDLE && phase != whp_pkg::PH_DONE)))
    |=> byte_offset <= file_length)
    else $error("offset ran past file length");
  a_ok_only_via_div: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && fin && !fin_ok) |-> fin_st != whp_pkg::ST_OK)
    else $error("ok status without division");
`endif

endmodule

>>> rtl/wav_header_parser_top.sv
// Top level of the WAV header parser: channels, config register, controller and datapath
`timescale 1ns / 1ps
// channel   dir  payload
// in        sink data_byte, first_byte
// out       src  status .. data_offset
// cfg       sink file_length
// One byte per cycle while parsing; a byte that completes a good header
// starts two passes of the shared bit-serial divider, of 32 and 42 steps,
// with the scale by 1000 between them, before the result is loaded.
// rst is synchronous; it clears the phase, parse registers and file_length.
// Intake stops during the divisions and the scale, and while a result waits in the
// output register and is not being taken.
module wav_header_parser_top (
  input logic           clk,
  input logic           rst,
  whp_in_if.sink        in_ch,
  whp_out_if.source     out_ch,
  whp_cfg_if.sink       cfg
);

  logic [31:0] file_length;
  logic        out_valid;
  whp_pkg::dp_cmd_t  cmd;
  whp_pkg::dp_stat_t stat;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) file_length <= '0;
    else if (cfg.valid) file_length <= cfg.data;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.emit) out_valid <= 1'b1;
    else if (out_ch.ready) out_valid <= 1'b0;
  end
  assign out_ch.valid = out_valid;

  whp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_valid), .out_ready(out_ch.ready), .stat(stat), .cmd(cmd)
  );

  whp_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .data_byte(in_ch.payload.data_byte), .first_byte(in_ch.payload.first_byte),
    .file_length(file_length), .result(out_ch.payload)
  );

endmodule
